// File: sv/dtu_pkg.sv
package dtu_pkg;

  // Address width of the byte memory.
  localparam int unsigned ADDR_BITS = 16;

  // Opcode field extraction.
  localparam logic [7:0] DST_MASK  = 8'h38;
  localparam logic [7:0] SRC_MASK  = 8'h07;
  localparam int unsigned DST_SHIFT = 3;

  // Register file codes as used in the opcode fields.
  localparam logic [2:0] REG_B = 3'd0;
  localparam logic [2:0] REG_C = 3'd1;
  localparam logic [2:0] REG_D = 3'd2;
  localparam logic [2:0] REG_E = 3'd3;
  localparam logic [2:0] REG_H = 3'd4;
  localparam logic [2:0] REG_L = 3'd5;
  localparam logic [2:0] REG_M = 3'd6;
  localparam logic [2:0] REG_A = 3'd7;

  // Opcodes and opcode group patterns.
  localparam logic [7:0] MVI_MASK  = 8'hC7;
  localparam logic [7:0] MVI_MATCH = 8'h06;
  localparam logic [1:0] MOV_GROUP = 2'b01;
  localparam logic [7:0] OP_HLT    = 8'h76;
  localparam logic [7:0] OP_LXI_B  = 8'h01;
  localparam logic [7:0] OP_LXI_D  = 8'h11;
  localparam logic [7:0] OP_LXI_H  = 8'h21;
  localparam logic [7:0] OP_LXI_SP = 8'h31;
  localparam logic [7:0] OP_STAX_B = 8'h02;
  localparam logic [7:0] OP_STAX_D = 8'h12;
  localparam logic [7:0] OP_LDAX_B = 8'h0A;
  localparam logic [7:0] OP_LDAX_D = 8'h1A;
  localparam logic [7:0] OP_STA    = 8'h32;
  localparam logic [7:0] OP_LDA    = 8'h3A;
  localparam logic [7:0] OP_SHLD   = 8'h22;
  localparam logic [7:0] OP_LHLD   = 8'h2A;
  localparam logic [7:0] OP_XCHG   = 8'hEB;

  typedef enum logic [1:0] {
    KIND_EXEC  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // One input word.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  opcode;
    logic [7:0]  imm_low;
    logic [7:0]  imm_high;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [7:0]  reg_a;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [7:0]  reg_d;
    logic [7:0]  reg_e;
    logic [7:0]  reg_h;
    logic [7:0]  reg_l;
    logic [15:0] stack_ptr;
    logic [7:0]  read_data;
    logic        unsupported;
  } result_t;

endpackage

// File: sv/dtu_ram.sv
module dtu_ram #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  // Single port, registered read; the read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/dtu_core.sv
module dtu_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dtu_pkg::item_t  in_item_i,
  input  logic            out_free_i,
  output logic            res_valid_o,
  output dtu_pkg::result_t res_o
);
  import dtu_pkg::*;

  // Writeback stage: what happens when the RAM read data arrives.
  typedef struct packed {
    logic       emit;
    logic       ld;
    logic       ld_rd;
    logic [2:0] idx;
    logic       unsup;
  } wb_t;

  logic [7:0]  regs_q [8];
  logic [7:0]  regs_d [8];
  logic [7:0]  cur_regs [8];
  logic [15:0] sp_q, sp_d;

  logic        w_valid_q;
  wb_t         w_q, new_w;
  logic        new_wv;

  logic                 ph_valid_q, ph_lhld_q;
  logic [ADDR_BITS-1:0] ph_addr_q;
  logic                 ph_start, ph_lhld;

  logic                 dec_en, dec_we;
  logic [ADDR_BITS-1:0] dec_addr;
  logic [7:0]           dec_wdata;

  logic                 ram_en, ram_we;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [7:0]           ram_wdata, ram_rdata;

  logic w_go, issue_ok, acc, issue_ph;
  logic [2:0] dst, src;
  logic [15:0] hl, bc, de, direct;
  logic [ADDR_BITS-1:0] direct_a;

  // Handshake and stage advance.
  assign w_go       = w_valid_q && (!w_q.emit || out_free_i);
  assign issue_ok   = !w_valid_q || w_go;
  assign in_ready_o = issue_ok && !ph_valid_q && !(w_valid_q && w_q.ld);
  assign acc        = in_valid_i && in_ready_o;
  assign issue_ph   = ph_valid_q && issue_ok;

  // Operand fields and register-pair addresses.
  assign dst      = 3'((in_item_i.opcode & DST_MASK) >> DST_SHIFT);
  assign src      = 3'(in_item_i.opcode & SRC_MASK);
  assign hl       = {regs_q[REG_H], regs_q[REG_L]};
  assign bc       = {regs_q[REG_B], regs_q[REG_C]};
  assign de       = {regs_q[REG_D], regs_q[REG_E]};
  assign direct   = {in_item_i.imm_high, in_item_i.imm_low};
  assign direct_a = direct[ADDR_BITS-1:0];

  // Decode of the word at the input.
  always_comb begin
    regs_d    = regs_q;
    sp_d      = sp_q;
    dec_en    = 1'b0;
    dec_we    = 1'b0;
    dec_addr  = hl[ADDR_BITS-1:0];
    dec_wdata = regs_q[REG_A];
    new_wv    = 1'b1;
    new_w     = '{emit: 1'b1, ld: 1'b0, ld_rd: 1'b0, idx: REG_A, unsup: 1'b0};
    ph_start  = 1'b0;
    ph_lhld   = 1'b0;
    case (in_item_i.kind)
      KIND_EXEC: begin
        if ((in_item_i.opcode & MVI_MASK) == MVI_MATCH) begin
          if (dst == REG_M) begin
            dec_en    = 1'b1;
            dec_we    = 1'b1;
            dec_wdata = in_item_i.imm_low;
          end else begin
            regs_d[dst] = in_item_i.imm_low;
          end
        end else if (in_item_i.opcode[7:6] == MOV_GROUP) begin
          if (in_item_i.opcode == OP_HLT) begin
            new_w.unsup = 1'b1;
          end else if (dst == REG_M) begin
            dec_en    = 1'b1;
            dec_we    = 1'b1;
            dec_wdata = regs_q[src];
          end else if (src == REG_M) begin
            dec_en    = 1'b1;
            new_w.ld  = 1'b1;
            new_w.idx = dst;
          end else begin
            regs_d[dst] = regs_q[src];
          end
        end else begin
          case (in_item_i.opcode)
            OP_LXI_B: begin
              regs_d[REG_C] = in_item_i.imm_low;
              regs_d[REG_B] = in_item_i.imm_high;
            end
            OP_LXI_D: begin
              regs_d[REG_E] = in_item_i.imm_low;
              regs_d[REG_D] = in_item_i.imm_high;
            end
            OP_LXI_H: begin
              regs_d[REG_L] = in_item_i.imm_low;
              regs_d[REG_H] = in_item_i.imm_high;
            end
            OP_LXI_SP: sp_d = direct;
            OP_STAX_B: begin
              dec_en   = 1'b1;
              dec_we   = 1'b1;
              dec_addr = bc[ADDR_BITS-1:0];
            end
            OP_STAX_D: begin
              dec_en   = 1'b1;
              dec_we   = 1'b1;
              dec_addr = de[ADDR_BITS-1:0];
            end
            OP_LDAX_B: begin
              dec_en   = 1'b1;
              dec_addr = bc[ADDR_BITS-1:0];
              new_w.ld = 1'b1;
            end
            OP_LDAX_D: begin
              dec_en   = 1'b1;
              dec_addr = de[ADDR_BITS-1:0];
              new_w.ld = 1'b1;
            end
            OP_STA: begin
              dec_en   = 1'b1;
              dec_we   = 1'b1;
              dec_addr = direct_a;
            end
            OP_LDA: begin
              dec_en   = 1'b1;
              dec_addr = direct_a;
              new_w.ld = 1'b1;
            end
            OP_SHLD: begin
              // L goes out now; H follows from the second-byte sequencer.
              dec_en    = 1'b1;
              dec_we    = 1'b1;
              dec_addr  = direct_a;
              dec_wdata = regs_q[REG_L];
              new_wv    = 1'b0;
              ph_start  = 1'b1;
            end
            OP_LHLD: begin
              // L is read now and written back silently; H gives the result.
              dec_en     = 1'b1;
              dec_addr   = direct_a;
              new_w.emit = 1'b0;
              new_w.ld   = 1'b1;
              new_w.idx  = REG_L;
              ph_start   = 1'b1;
              ph_lhld    = 1'b1;
            end
            OP_XCHG: begin
              regs_d[REG_D] = regs_q[REG_H];
              regs_d[REG_H] = regs_q[REG_D];
              regs_d[REG_E] = regs_q[REG_L];
              regs_d[REG_L] = regs_q[REG_E];
            end
            default: new_w.unsup = 1'b1;
          endcase
        end
      end
      KIND_WRITE: begin
        dec_en    = 1'b1;
        dec_we    = 1'b1;
        dec_addr  = in_item_i.mem_addr[ADDR_BITS-1:0];
        dec_wdata = in_item_i.mem_data;
      end
      KIND_READ: begin
        dec_en      = 1'b1;
        dec_addr    = in_item_i.mem_addr[ADDR_BITS-1:0];
        new_w.ld_rd = 1'b1;
      end
      default: ;
    endcase
  end

  // RAM port: the second byte of SHLD or LHLD has priority over new words.
  always_comb begin
    if (ph_valid_q) begin
      ram_en    = issue_ok;
      ram_we    = !ph_lhld_q;
      ram_addr  = ph_addr_q;
      ram_wdata = regs_q[REG_H];
    end else begin
      ram_en    = dec_en && acc;
      ram_we    = dec_we;
      ram_addr  = dec_addr;
      ram_wdata = dec_wdata;
    end
  end

  dtu_ram #(
    .AW (ADDR_BITS),
    .DW (8)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Register file and stack pointer. A load from memory lands at writeback.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        regs_q[i] <= '0;
      end
      sp_q <= '0;
    end else if (acc) begin
      regs_q <= regs_d;
      sp_q   <= sp_d;
    end else if (w_go && w_q.ld) begin
      regs_q[w_q.idx] <= ram_rdata;
    end
  end

  // Second-byte sequencer for SHLD and LHLD.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_valid_q <= 1'b0;
    end else if (acc && ph_start) begin
      ph_valid_q <= 1'b1;
    end else if (issue_ph) begin
      ph_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && ph_start) begin
      ph_lhld_q <= ph_lhld;
      ph_addr_q <= direct_a + ADDR_BITS'(1);
    end
  end

  // Writeback stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
    end else if (acc) begin
      w_valid_q <= new_wv;
    end else if (issue_ph) begin
      w_valid_q <= 1'b1;
    end else if (w_go) begin
      w_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      w_q <= new_w;
    end else if (issue_ph) begin
      w_q <= '{emit: 1'b1, ld: ph_lhld_q, ld_rd: 1'b0, idx: REG_H, unsup: 1'b0};
    end
  end

  // Result: register state with the arriving load folded in.
  always_comb begin
    cur_regs = regs_q;
    if (w_q.ld) begin
      cur_regs[w_q.idx] = ram_rdata;
    end
  end

  assign res_valid_o       = w_go && w_q.emit;
  assign res_o.reg_a       = cur_regs[REG_A];
  assign res_o.reg_b       = cur_regs[REG_B];
  assign res_o.reg_c       = cur_regs[REG_C];
  assign res_o.reg_d       = cur_regs[REG_D];
  assign res_o.reg_e       = cur_regs[REG_E];
  assign res_o.reg_h       = cur_regs[REG_H];
  assign res_o.reg_l       = cur_regs[REG_L];
  assign res_o.stack_ptr   = sp_q;
  assign res_o.read_data   = w_q.ld_rd ? ram_rdata : 8'h00;
  assign res_o.unsupported = w_q.unsup;

endmodule

// File: sv/i8080_data_transfer_unit_top.sv
// Channel   Dir  Signals                    Contents
// s_axis    in   tvalid tready tdata tuser  instruction or memory access word
// m_axis    out  tvalid tready tdata        registers after the step
//
// Words that load a register from memory (MOV r,M, LDAX, LDA) hold the input
// until the data arrives, since the single RAM port has a registered read;
// SHLD and LHLD make one RAM access per byte.
// Reset clears the registers and the stack pointer; the byte memory is not
// cleared. A stalled output holds the writeback stage and with it the input.
module i8080_data_transfer_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // opcode, imm_low, imm_high, mem_addr, mem_data
  input  logic [47:0] s_axis_tdata_i,
  // kind
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // reg_a, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l, stack_ptr, read_data,
  // unsupported, zero fill
  output logic [87:0] m_axis_tdata_o
);
  import dtu_pkg::*;

  item_t   item;
  result_t res, out_q;
  logic    res_valid, out_valid_q, out_free;

  // Unpack the input word.
  assign item.kind     = kind_e'(s_axis_tuser_i);
  assign item.opcode   = s_axis_tdata_i[7:0];
  assign item.imm_low  = s_axis_tdata_i[15:8];
  assign item.imm_high = s_axis_tdata_i[23:16];
  assign item.mem_addr = s_axis_tdata_i[39:24];
  assign item.mem_data = s_axis_tdata_i[47:40];

  assign out_free = !out_valid_q || m_axis_tready_i;

  dtu_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (item),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.unsupported, out_q.read_data, out_q.stack_ptr,
                            out_q.reg_l, out_q.reg_h, out_q.reg_e, out_q.reg_d,
                            out_q.reg_c, out_q.reg_b, out_q.reg_a};

`ifndef SYNTHESIS
  // A result is only produced when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free)
    else $error("result produced while output register is full");

  // Two-byte transfers and the LDA and LDAX B loads hold the input for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == KIND_EXEC &&
     (s_axis_tdata_i[7:0] == OP_SHLD || s_axis_tdata_i[7:0] == OP_LHLD ||
      s_axis_tdata_i[7:0] == OP_LDA || s_axis_tdata_i[7:0] == OP_LDAX_B))
    |=> !s_axis_tready_o)
    else $error("input accepted during a multi-cycle transfer");

  // A plain memory write produces its result in the following cycle unless the
  // output register is still full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == KIND_WRITE)
    |=> (res_valid || !out_free))
    else $error("memory write word did not complete");
`endif

endmodule
